### hdl/bfpa_pkg.sv
`timescale 1ns / 1ps

package bfpa_pkg;

    // Character codes, already reduced to six bits.
    localparam logic [5:0] CH_SPACE = 6'd32;
    localparam logic [5:0] CH_STAR  = 6'd42;
    localparam logic [5:0] CH_DOT   = 6'd46;
    localparam logic [5:0] CH_ZERO  = 6'd48;

    // Values at or above this bound print as all stars.
    localparam logic [31:0] OVERFLOW_AT = 32'd256000;

    // One classified item: overflow flag and the five decimal digits.
    typedef struct packed {
        logic       ovf;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
        logic [3:0] frac_tens;
        logic [3:0] frac_ones;
    } entry_t;

    function automatic logic [5:0] digit_char(input logic [3:0] d);
        digit_char = CH_ZERO + {2'b00, d};
    endfunction

endpackage

### hdl/binary_fixed_point_to_ascii.sv
`timescale 1ns / 1ps

// Formats an unsigned 32-bit fixed-point number (resolution 1/256) as a
// six-character decimal field: three integer places right-justified with
// spaces, a point, and two truncated fraction digits. Values of 256000 and
// above print as "***.**".
// Input channel: value with in_valid/in_stall; a transaction is taken at a
// rising edge where in_valid is high and in_stall is low.
// Output channel: character and last with out_valid/out_stall; each input
// transaction yields six output transactions, last marking the sixth.
// The value is registered in the front register and then written into the
// queue; the first character is offered once its entry heads the queue.
// The back end gives one character per cycle while out_stall is low, through
// its single character port.
// The front end classifies items and computes digits, a two-entry queue
// holds them, so new input is taken while the back end still streams.
// When out_stall is high the current character holds; once the queue and
// the front register fill, in_stall rises.
// Reset clears the front register, the queue and the character position;
// no output is valid after reset until an input transaction arrives.
module binary_fixed_point_to_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  character,
    output logic        last
);
    import bfpa_pkg::*;

    entry_t push_entry;
    entry_t head_entry;
    logic   push_valid;
    logic   q_full;
    logic   head_valid;
    logic   pop;

    // Front end: accepts the value and splits it into decimal digits.
    bfpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .push_valid (push_valid),
        .q_full     (q_full),
        .push_entry (push_entry)
    );

    // Short queue decoupling the front end from the character stream.
    bfpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Back end: walks the six positions of the head entry.
    bfpa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .character  (character),
        .last       (last)
    );

endmodule

### hdl/bfpa_front.sv
`timescale 1ns / 1ps

module bfpa_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [31:0]      value,
    output logic             push_valid,
    input  logic             q_full,
    output bfpa_pkg::entry_t push_entry
);
    import bfpa_pkg::*;

    // First stage: overflow check, integer part and scaled fraction.
    logic        s_vld_reg, s_vld_next;
    logic        ovf_reg;
    logic [9:0]  ip_reg;
    logic [6:0]  fr_reg;
    logic [14:0] fr_prod;
    logic        accept;

    // Second stage logic: digits by reciprocal multiplication.
    logic [15:0] h_prod;
    logic [17:0] q10_prod;
    logic [14:0] ft_prod;
    logic [3:0]  hund;
    logic [6:0]  q10;
    logic [9:0]  ones_w;
    logic [6:0]  tens_w;
    logic [3:0]  frac_tens;
    logic [6:0]  frac_ones_w;

    assign in_stall   = s_vld_reg && q_full;
    assign accept     = in_valid && !in_stall;
    assign push_valid = s_vld_reg;
    assign fr_prod    = 15'(value[7:0]) * 15'd100;

    always_comb
    begin
        s_vld_next = s_vld_reg;
        if (accept)
        begin
            s_vld_next = 1'b1;
        end
        else if (s_vld_reg && !q_full)
        begin
            s_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg <= 1'b0;
        end
        else
        begin
            s_vld_reg <= s_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ovf_reg <= (value >= OVERFLOW_AT);
            ip_reg  <= value[17:8];
            fr_reg  <= fr_prod[14:8];
        end
    end

    // x/100 = (x*41)>>12 and x/10 = (x*205)>>11 hold for the ranges used.
    always_comb
    begin
        h_prod      = 16'(ip_reg) * 16'd41;
        q10_prod    = 18'(ip_reg) * 18'd205;
        ft_prod     = 15'(fr_reg) * 15'd205;
        hund        = h_prod[15:12];
        q10         = q10_prod[17:11];
        ones_w      = ip_reg - ({q10, 3'b000} + {2'b00, q10, 1'b0});
        tens_w      = q10 - 7'({hund, 3'b000} + {2'b00, hund, 1'b0});
        frac_tens   = ft_prod[14:11];
        frac_ones_w = fr_reg - 7'({frac_tens, 3'b000} + {2'b00, frac_tens, 1'b0});

        push_entry.ovf       = ovf_reg;
        push_entry.hund      = hund;
        push_entry.tens      = tens_w[3:0];
        push_entry.ones      = ones_w[3:0];
        push_entry.frac_tens = frac_tens;
        push_entry.frac_ones = frac_ones_w[3:0];
    end

endmodule

### hdl/bfpa_queue.sv
`timescale 1ns / 1ps

module bfpa_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  bfpa_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output bfpa_pkg::entry_t head_entry
);
    import bfpa_pkg::*;

    entry_t     mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hdl/bfpa_back.sv
`timescale 1ns / 1ps

module bfpa_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  bfpa_pkg::entry_t head_entry,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [5:0]       character,
    output logic             last
);
    import bfpa_pkg::*;

    typedef enum logic [2:0] {
        POS_HUND,
        POS_TENS,
        POS_ONES,
        POS_DOT,
        POS_FRT,
        POS_FRO
    } pos_t;

    pos_t pos_reg, pos_next;
    logic take;
    logic show_h;
    logic show_t;

    assign out_valid = head_valid;
    assign take      = head_valid && !out_stall;
    assign last      = (pos_reg == POS_FRO);
    assign pop       = take && last;
    assign show_h    = (head_entry.hund != 4'd0);
    assign show_t    = show_h || (head_entry.tens != 4'd0);

    always_comb
    begin
        pos_next = pos_reg;
        if (take)
        begin
            unique case (pos_reg)
                POS_HUND: pos_next = POS_TENS;
                POS_TENS: pos_next = POS_ONES;
                POS_ONES: pos_next = POS_DOT;
                POS_DOT:  pos_next = POS_FRT;
                POS_FRT:  pos_next = POS_FRO;
                POS_FRO:  pos_next = POS_HUND;
                default:  pos_next = POS_HUND;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUND;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_comb
    begin
        character = CH_STAR;
        if (pos_reg == POS_DOT)
        begin
            character = CH_DOT;
        end
        else if (!head_entry.ovf)
        begin
            unique case (pos_reg)
                POS_HUND: character = show_h ? digit_char(head_entry.hund) : CH_SPACE;
                POS_TENS: character = show_t ? digit_char(head_entry.tens) : CH_SPACE;
                POS_ONES: character = digit_char(head_entry.ones);
                POS_FRT:  character = digit_char(head_entry.frac_tens);
                POS_FRO:  character = digit_char(head_entry.frac_ones);
                default:  character = CH_DOT;
            endcase
        end
    end

endmodule

### tb/sv/binary_fixed_point_to_ascii_chk.sv
`timescale 1ns / 1ps

module binary_fixed_point_to_ascii_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  character,
    input  logic        last,
    output int          mismatch_count,
    output int          chars_pending
);
    import bfpa_pkg::*;

    typedef struct packed {
        logic [5:0] ch;
        logic       last;
    } field_char_t;

    field_char_t expected_chars[$];
    field_char_t oldest;

    function automatic logic [5:0] digit_code(input int unsigned d);
        logic [5:0] d6;
        d6 = 6'(d);
        return CH_ZERO + d6;
    endfunction

    // Builds the six characters that one number prints as and queues them.
    task automatic queue_field(input logic [31:0] v);
        int unsigned whole;
        int unsigned frac;
        logic [5:0]  c [6];
        field_char_t fc;
        if (v >= OVERFLOW_AT)
        begin
            c[0] = CH_STAR;
            c[1] = CH_STAR;
            c[2] = CH_STAR;
            c[3] = CH_DOT;
            c[4] = CH_STAR;
            c[5] = CH_STAR;
        end
        else
        begin
            whole = v >> 8;
            frac  = ((v & 32'hFF) * 100) >> 8;
            c[0]  = (whole >= 100) ? digit_code(whole / 100) : CH_SPACE;
            c[1]  = (whole >= 10) ? digit_code((whole / 10) % 10) : CH_SPACE;
            c[2]  = digit_code(whole % 10);
            c[3]  = CH_DOT;
            c[4]  = digit_code(frac / 10);
            c[5]  = digit_code(frac % 10);
        end
        for (int k = 0; k < 6; k++)
        begin
            fc.ch   = c[k];
            fc.last = (k == 5);
            expected_chars.push_back(fc);
        end
    endtask

    task automatic note_mismatch(input string what, input int exp_v, input int act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what,
                     exp_v, act_v);
    endtask

    initial
    begin
        mismatch_count = 0;
        chars_pending  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_chars.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                queue_field(value);
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    note_mismatch("character with nothing expected", -1,
                                  int'(character));
                end
                else
                begin
                    oldest = expected_chars.pop_front();
                    if (character !== oldest.ch)
                        note_mismatch("character", int'(oldest.ch), int'(character));
                    if (last !== oldest.last)
                        note_mismatch("last", int'(oldest.last), int'(last));
                end
            end
        end
        chars_pending = expected_chars.size();
    end

endmodule

### tb/sv/binary_fixed_point_to_ascii_tb.sv
`timescale 1ns / 1ps

// Top of the formatter testbench. It makes the clock and the reset, drives
// numbers into the block and applies back pressure on the character side.
// All prediction and comparison lives in the checker next to the block; this
// module only reads the checker's mismatch count and the number of characters
// still owed, and prints the verdict.
module binary_fixed_point_to_ascii_tb;

    import bfpa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] value;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  character;
    logic        last;

    int mismatch_count;
    int chars_pending;

    // Number of items that are sent back to back, with no idle cycle.
    int back_to_back_left;

    binary_fixed_point_to_ascii u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    binary_fixed_point_to_ascii_chk u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .character      (character),
        .last           (last),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle cycles before the next input transaction. Mostly none or a few,
    // now and then a long pause, and every so often a burst of items that
    // go in back to back so the internal queue fills up.
    function automatic int input_gap();
        int r;
        if (back_to_back_left > 0)
        begin
            back_to_back_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            back_to_back_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Random number to format. Most land in the printable range with the
    // integer part spread over one, two and three digits; some sit right at
    // the overflow bound, and the rest cover the full 32-bit range, which
    // mostly overflows and exercises every bit of the port.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return $urandom_range(0, 10 * 256 - 1);
        if (r < 30)
            return $urandom_range(10 * 256, 100 * 256 - 1);
        if (r < 60)
            return $urandom_range(100 * 256, OVERFLOW_AT - 1);
        if (r < 75)
            return $urandom_range(OVERFLOW_AT - 300, OVERFLOW_AT + 300);
        return $urandom();
    endfunction

    // Offers one number and returns once the block has taken it. The valid
    // line stays high into the next transaction when there is no gap, so it
    // is never lowered and raised within the same time step.
    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = input_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Back pressure on the character channel: free runs of varied length,
    // including long ones with no stall at all, alternating with stalls of
    // varied length.
    initial
    begin
        int free_run;
        int hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            case ($urandom_range(0, 9))
                0, 1:    free_run = $urandom_range(5, 15);
                2:       free_run = $urandom_range(40, 80);
                default: free_run = $urandom_range(1, 4);
            endcase
            out_stall <= 1'b0;
            repeat (free_run) @(posedge clk);
            case ($urandom_range(0, 19))
                0:          hold = $urandom_range(15, 30);
                1, 2, 3, 4: hold = $urandom_range(3, 6);
                default:    hold = $urandom_range(1, 2);
            endcase
            out_stall <= 1'b1;
            repeat (hold) @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [31:0] directed [$];
        int          waited;
        back_to_back_left = 0;
        in_valid <= 1'b0;
        value    <= 32'd0;
        rst_n    <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero, the smallest fraction steps (the fraction is
        // truncated, so 2/256 still prints .00 and 3/256 prints .01), the
        // largest fraction, every boundary where a leading space turns into
        // a digit, the largest printable value, the overflow bound itself,
        // values that are negative as signed numbers, and all ones.
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd26, 32'd128, 32'd255,
                     32'd256, 32'd2559, 32'd2560, 32'd25599, 32'd25600,
                     32'd31551, 32'd128000, 32'd255999, 32'd256000,
                     32'd256001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hFFFF_FFFF};
        foreach (directed[i])
            send_value(directed[i]);

        for (int n = 0; n < 208; n++)
            send_value(pick_value());
        in_valid <= 1'b0;

        // Drain: wait on the falling edge so the checker has finished its
        // bookkeeping for the rising edge before its counter is read.
        waited = 0;
        @(negedge clk);
        while (chars_pending != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        // Keep the clock running so that any stray character still shows up.
        repeat (20) @(negedge clk);

        if (mismatch_count == 0 && chars_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### binary_fixed_point_to_ascii.f
hdl/bfpa_pkg.sv
hdl/bfpa_front.sv
hdl/bfpa_queue.sv
hdl/bfpa_back.sv
hdl/binary_fixed_point_to_ascii.sv
tb/sv/binary_fixed_point_to_ascii_chk.sv
tb/sv/binary_fixed_point_to_ascii_tb.sv
